// ----- hw/rtl/sitd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared types, constants and functions of the signed integer to decimal
// text converter.
// ----------------------------------------------------------------------------
package sitd_pkg;

  // input word and output character widths
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;

  // decimal digits needed for a 32-bit magnitude
  localparam int BCD_DIGITS = 10;

  // size of the digit stack; only this many least significant digits are sent
  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_LIMIT = (MAX_DIGITS < 1) ? 1 :
                               ((MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS);

  // digit index width
  localparam int IDX_W = $clog2(BCD_DIGITS);

  // shift-add-3 conversion split over pipeline stages
  localparam int BITS_PER_STAGE = 8;
  localparam int NUM_STAGES     = VALUE_W / BITS_PER_STAGE;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  // one value in flight through the conversion
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] bin;
    bcd_t               bcd;
  } conv_t;

  // BITS_PER_STAGE steps of shift-add-3: adjust every digit, then shift one bit in
  function automatic conv_t dd_shift(input conv_t s);
    conv_t r;
    r = s;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (r.bcd[d] >= 4'd5) begin
          r.bcd[d] = r.bcd[d] + 4'd3;
        end
      end
      {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    end
    return r;
  endfunction

  // index of the first digit to send: most significant nonzero, capped by the stack
  function automatic logic [IDX_W-1:0] msd_index(input bcd_t b);
    logic [IDX_W-1:0] top;
    top = '0;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (b[d] != 4'd0) begin
        top = IDX_W'(d);
      end
    end
    if (top > IDX_W'(DIGIT_LIMIT - 1)) begin
      top = IDX_W'(DIGIT_LIMIT - 1);
    end
    return top;
  endfunction

  // every digit is a decimal digit
  function automatic logic bcd_is_valid(input bcd_t b);
    logic ok;
    ok = 1'b1;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (b[d] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ----- hw/rtl/sitd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_if
// Request channels of the converter: integer input and character output.
// ----------------------------------------------------------------------------

// integer request channel
interface sitd_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sitd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// character request channel
interface sitd_out_if;
  logic                        valid;
  logic                        ready;
  logic [sitd_pkg::CHAR_W-1:0] char_code;
  logic                        is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal text, one ASCII character
// per output request, most significant first, last character marked.
//
// Channels: din carries one signed 32-bit value per request; dout carries
// char_code ('-' or '0'..'9') and is_last, set on the final character.
// Negative values start with '-', zero gives "0", no leading zeros.
// Path: a value passes the sign/magnitude register, four shift-add-3 stages
// of eight bits each, the serializer load and the output register to dout.
// Throughput: a value of n characters (1 to 11) is loaded into the serializer,
// which sends one character per cycle while dout is ready and loads the next
// value only after the last character; the pipeline in front takes one value
// per cycle when not stalled and buffers up to five values behind it.
// Reset: rst clears all valid bits; nothing is kept between values.
// Stall: when dout is not ready the output register holds its character, the
// serializer and the pipeline stages hold their values and din drops ready
// once every stage is full.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  sitd_in_if.sink     din,
  sitd_out_if.source  dout
);

  localparam int NS = sitd_pkg::NUM_STAGES;

  logic                   front_valid;
  sitd_pkg::conv_t        front_data;
  logic [sitd_pkg::VALUE_W-1:0] raw;
  logic [NS:0]            chain_valid;
  logic [NS:0]            chain_ready;
  sitd_pkg::conv_t        chain_data [NS+1];
  logic                   ser_ready;

  // sign and magnitude register
  assign raw      = din.value;
  assign din.ready = chain_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      front_valid <= 1'b1;
    end else if (chain_ready[1]) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      front_data.neg <= raw[sitd_pkg::VALUE_W-1];
      front_data.bin <= raw[sitd_pkg::VALUE_W-1] ? (~raw + sitd_pkg::VALUE_W'(1)) : raw;
      front_data.bcd <= '0;
    end
  end

  assign chain_valid[0] = front_valid;
  assign chain_data[0]  = front_data;
  assign chain_ready[0] = !front_valid || chain_ready[1];

  // conversion stages
  for (genvar k = 0; k < NS; k++) begin : g_stage
    sitd_bcd_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k+1]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (k + 1 < NS ? chain_ready[k+2 > NS ? NS : k+2] : ser_ready),
      .out_data  (chain_data[k+1])
    );
  end

  // character serializer
  sitd_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[NS]),
    .in_ready (ser_ready),
    .in_data  (chain_data[NS]),
    .dout     (dout)
  );

  // checks
  a_bin_drained: assert property (@(posedge clk) disable iff (rst)
    chain_valid[NS] |-> (chain_data[NS].bin == '0))
    else $error("magnitude bits left after conversion");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    chain_valid[NS] |-> sitd_pkg::bcd_is_valid(chain_data[NS].bcd))
    else $error("conversion produced a non-decimal digit");

  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    (chain_valid[NS] && !ser_ready) |=> (chain_valid[NS] && $stable(chain_data[NS])))
    else $error("converted value lost while serializer busy");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.char_code == sitd_pkg::CHAR_MINUS) |-> !dout.is_last)
    else $error("minus sign marked as last character");

endmodule

// ----- hw/rtl/sitd_bcd_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_bcd_stage
// One register stage of the binary to BCD conversion, shifting in a slice
// of the magnitude bits with a valid/ready hold on stall.
// ----------------------------------------------------------------------------
module sitd_bcd_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sitd_pkg::conv_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sitd_pkg::conv_t out_data
);

  // stage takes a request when empty or when its content moves on
  assign in_ready = !out_valid || out_ready;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // conversion slice
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= sitd_pkg::dd_shift(in_data);
    end
  end

endmodule

// ----- hw/rtl/sitd_serializer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitd_serializer
// Holds one converted value and sends its sign and digits as characters,
// one per cycle while dout is ready, through an output register.
// ----------------------------------------------------------------------------
module sitd_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sitd_pkg::conv_t  in_data,
  sitd_out_if.source       dout
);

  logic                          have_item;
  logic                          sign_pending;
  logic [sitd_pkg::IDX_W-1:0]    idx;
  sitd_pkg::bcd_t                digits;
  logic                          out_free;
  logic                          fire;
  logic                          load;

  // handshake terms
  assign in_ready = !have_item;
  assign load     = in_valid && in_ready;
  assign out_free = !dout.valid || dout.ready;
  assign fire     = have_item && out_free;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_item    <= 1'b0;
      sign_pending <= 1'b0;
      dout.valid   <= 1'b0;
    end else begin
      if (load) begin
        have_item    <= 1'b1;
        sign_pending <= in_data.neg;
      end else if (fire) begin
        if (sign_pending) begin
          sign_pending <= 1'b0;
        end else if (idx == '0) begin
          have_item <= 1'b0;
        end
      end
      if (fire) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
    end
  end

  // digit pointer and held digits
  always_ff @(posedge clk) begin
    if (load) begin
      idx    <= sitd_pkg::msd_index(in_data.bcd);
      digits <= in_data.bcd;
    end else if (fire && !sign_pending && idx != '0) begin
      idx <= idx - sitd_pkg::IDX_W'(1);
    end
  end

  // output character register
  always_ff @(posedge clk) begin
    if (fire) begin
      if (sign_pending) begin
        dout.char_code <= sitd_pkg::CHAR_MINUS;
        dout.is_last   <= 1'b0;
      end else begin
        dout.char_code <= sitd_pkg::CHAR_ZERO + {4'b0000, digits[idx]};
        dout.is_last   <= (idx == '0);
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signed integer to decimal text converter.
// Values go in on din and every character out on dout is compared with a
// local prediction of the decimal text. The run covers directed edge values,
// random values under several idle and stall mixes, and a long output
// hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DIGIT_CAP    = (sitd_pkg::MAX_DIGITS < 1) ? 1 :
                                ((sitd_pkg::MAX_DIGITS > 20) ? 20 : sitd_pkg::MAX_DIGITS);
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 70;

  typedef struct packed {
    logic [sitd_pkg::CHAR_W-1:0] code;
    logic                        last;
  } char_item_t;

  logic clk;
  logic rst;

  sitd_in_if  in_ch ();
  sitd_out_if out_ch ();

  signed_int_to_decimal_ascii dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  char_item_t pending_chars[$];
  int         failures       = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_tickets   = 0;
  int         hold_served    = 0;
  int         hold_left      = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // queue the characters of one value's decimal text
  function automatic void predict_text(input logic [sitd_pkg::VALUE_W-1:0] word);
    logic [sitd_pkg::VALUE_W-1:0] mag;
    logic                         neg;
    logic [3:0]                   digs[$];
    char_item_t                   item;
    neg = word[sitd_pkg::VALUE_W-1];
    mag = neg ? (~word + 1'b1) : word;
    if (mag == '0) begin
      digs.push_back(4'd0);
    end
    while (mag != '0 && digs.size() < DIGIT_CAP) begin
      digs.push_back(4'(mag % 32'd10));
      mag = mag / 32'd10;
    end
    if (neg) begin
      item.code = sitd_pkg::CHAR_MINUS;
      item.last = 1'b0;
      pending_chars.push_back(item);
    end
    for (int i = digs.size() - 1; i >= 0; i--) begin
      item.code = sitd_pkg::CHAR_ZERO + sitd_pkg::CHAR_W'(digs[i]);
      item.last = (i == 0);
      pending_chars.push_back(item);
    end
  endfunction

  // random value spread over all magnitudes, signs and digit counts
  function automatic logic [sitd_pkg::VALUE_W-1:0] pick_value();
    logic [sitd_pkg::VALUE_W-1:0] v;
    logic [sitd_pkg::VALUE_W-1:0] pow;
    int                           k;
    pow = 32'd1;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(99);
      2: v = $urandom >> $urandom_range(31);
      default: begin
        k = $urandom_range(9);
        for (int i = 0; i < k; i++) pow = pow * 32'd10;
        v = pow + $urandom_range(2) - 1;
      end
    endcase
    if ($urandom_range(1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  // offer one request on din, return at the falling edge after it is taken
  task automatic send_value(input logic [sitd_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= $urandom;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_text(v);
    @(negedge clk);
  endtask

  // stop offering and wait for every pending character
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // edge values: zero, single digits, powers of ten, extremes
  task automatic test_directed();
    logic [sitd_pkg::VALUE_W-1:0] vals[$];
    vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             32'd999999999, -32'sd999999999, 32'd123456789, 32'h5555_5555,
             32'hAAAA_AAAA, -32'sd5, -32'sd1000000000, 32'd4294967};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (vals[i]) send_value(vals[i]);
    drain();
  endtask

  // random values under one idle and stall mix
  task automatic test_random(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_value(pick_value());
    drain();
  endtask

  // long output hold-off while values keep coming, so din must stall
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_tickets++;
    repeat (24) send_value(pick_value());
    drain();
  endtask

  // output ready: random stalls, plus the long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_tickets) begin
        hold_served = hold_tickets;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each accepted character with the oldest prediction
  always @(posedge clk) begin : check_chars
    char_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character %0d (is_last %0b) with no request pending",
               out_ch.char_code, out_ch.is_last);
        failures++;
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.char_code !== want.code) begin
          $error("char_code mismatch: expected %0d, got %0d", want.code, out_ch.char_code);
          failures++;
        end
        if (out_ch.is_last !== want.last) begin
          $error("is_last mismatch: expected %0b, got %0b", want.last, out_ch.is_last);
          failures++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(0, 0, PHASE_ITEMS);
    test_random(76, 0, PHASE_ITEMS);
    test_random(0, 76, PHASE_ITEMS);
    test_random(13, 13, PHASE_ITEMS);
    test_backpressure();
    if (failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- signed_int_to_decimal_ascii.f -----
hw/rtl/sitd_pkg.sv
hw/rtl/sitd_if.sv
hw/rtl/sitd_bcd_stage.sv
hw/rtl/sitd_serializer.sv
hw/rtl/signed_int_to_decimal_ascii.sv
test/testbench.sv
